/* rtl/bfns_pkg.sv */
// ----------------------------------------------------------------------------
// bfns_pkg
// Shared types and constants of the bitmap next-bit search block: action
// codes, field widths, default sizes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package bfns_pkg;

  // field widths of the stream items
  localparam int ACTION_W = 2;
  localparam int WIDX_W   = 6;
  localparam int DATA_W   = 64;
  localparam int IDX_W    = 13;

  // packed port widths
  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  // default sizes
  localparam int WORDS_DEF     = 64;
  localparam int WORD_BITS_DEF = 64;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_WRITE     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FIND_SET  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FIND_ZERO = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic wr;        // store the word of a write item
    logic load;      // capture the fields of a search item
    logic div;       // offset to word number, early-exit check
    logic setup;     // word pointer, bit position and base index
    logic read;      // read the first word
    logic scan;      // examine one word, prefetch the next
    logic out_load;  // move the answer into the output register
  } bfns_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic early;     // offset at or past the searchable end
    logic done;      // scan finished on this word
  } bfns_sts_t;

endpackage

/* rtl/bfns_ram.sv */
// ----------------------------------------------------------------------------
// bfns_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfns_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/bfns_ctrl.sv */
// ----------------------------------------------------------------------------
// bfns_ctrl
// Sequencer of the bitmap search: accepts items, steps the datapath through
// divide, setup, first read and word scan, and owns the output valid flag.
// ----------------------------------------------------------------------------
module bfns_ctrl
  import bfns_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [ACTION_W-1:0] in_action,
  output logic                out_tvalid,
  input  logic                out_tready,
  output bfns_cmd_t           cmd,
  input  bfns_sts_t           sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_POST  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       fire;
  logic       is_search;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign fire       = in_tvalid && in_tready;
  assign is_search  = (in_action == ACT_FIND_SET) || (in_action == ACT_FIND_ZERO);

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.wr       = fire && (in_action == ACT_WRITE);
    cmd.load     = fire && is_search;
    cmd.div      = (state_r == S_DIV);
    cmd.setup    = (state_r == S_SETUP);
    cmd.read     = (state_r == S_READ);
    cmd.scan     = (state_r == S_SCAN);
    cmd.out_load = (state_r == S_POST) && (!out_valid_r || out_tready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (fire && is_search) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        state_nxt = sts.early ? S_POST : S_SETUP;
      end
      S_SETUP: state_nxt = S_READ;
      S_READ:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.done) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (cmd.out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // a finished answer reaches the output register in the next cycle
  a_post_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("answer not presented after post");

  // a search leaves the idle state for the divide step
  a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_DIV))
    else $error("search did not start");

  // no write is taken while a search is in flight
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (state_r == S_IDLE))
    else $error("write taken while busy");
`endif

endmodule

/* rtl/bfns_dp.sv */
// ----------------------------------------------------------------------------
// bfns_dp
// Datapath of the bitmap search: bitmap memory, offset split into word and
// bit, per-word match and lowest-bit encode, answer and output registers.
// ----------------------------------------------------------------------------
module bfns_dp
  import bfns_pkg::*;
#(
  parameter int WORDS     = WORDS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bfns_cmd_t           cmd,
  output bfns_sts_t           sts,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [WIDX_W-1:0]   in_word_index,
  input  logic [DATA_W-1:0]   in_word_data,
  input  logic [IDX_W-1:0]    in_bit_limit,
  input  logic [IDX_W-1:0]    in_start_offset,
  output logic [IDX_W-1:0]    out_found_index
);

  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int POS_W  = $clog2(WORD_BITS);
  localparam int TOTAL  = WORDS * WORD_BITS;
  localparam int TW     = $clog2(TOTAL + 1);
  localparam int EW     = (TW > IDX_W + 1) ? TW : IDX_W + 1;
  localparam int Q_W    = $clog2((2**IDX_W - 1) / WORD_BITS + 1);
  localparam int DIV_SH = IDX_W + 6;
  localparam int RECIP  = (2**DIV_SH + WORD_BITS - 1) / WORD_BITS;
  localparam int RW     = $clog2(RECIP + 1);
  localparam int PW     = IDX_W + RW;

  // search registers
  logic                 mode_set_r;
  logic [IDX_W-1:0]     limit_r;
  logic [IDX_W-1:0]     offset_r;
  logic [Q_W-1:0]       q_r;
  logic [AW-1:0]        w_r;
  logic [POS_W-1:0]     bit_r;
  logic [EW-1:0]        base_r;
  logic [IDX_W-1:0]     res_r;
  logic [IDX_W-1:0]     out_found_r;

  // memory ports
  logic                 wr_en;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;

  // combinational values
  logic [EW-1:0]        eff_end;
  logic [PW-1:0]        prod;
  logic [Q_W-1:0]       q_nxt;
  logic [EW-1:0]        base_nxt;
  logic [EW-1:0]        bit_diff;
  logic [AW:0]          w_next;
  logic [WORD_BITS-1:0] sel;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] onehot;
  logic [POS_W-1:0]     pos;
  logic                 hit;
  logic [EW-1:0]        cand_idx;
  logic                 last_word;
  logic [IDX_W-1:0]     answer;
  logic                 res_load;

  // bitmap storage
  assign wr_en = cmd.wr && (int'(in_word_index) < WORDS);

  bfns_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_word_index)),
    .wr_data (in_word_data[WORD_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // searchable end: the limit, cut at the bitmap size
  assign eff_end = (EW'(limit_r) < EW'(TOTAL)) ? EW'(limit_r) : EW'(TOTAL);

  // word number of the offset by reciprocal multiply, exact for 13-bit offsets
  assign prod  = PW'(offset_r) * PW'(RECIP);
  assign q_nxt = prod[DIV_SH +: Q_W];

  // base index of that word and bit position inside it
  assign base_nxt = EW'(q_r) * EW'(WORD_BITS);
  assign bit_diff = EW'(offset_r) - base_nxt;

  // first read at the start word, then prefetch the following word
  assign w_next  = {1'b0, w_r} + 1'b1;
  assign rd_en   = cmd.read || (cmd.scan && (int'(w_next) < WORDS));
  assign rd_addr = cmd.read ? w_r : w_next[AW-1:0];

  // match vector of the current word, bits below the start masked off
  assign sel    = mode_set_r ? rd_data : ~rd_data;
  assign cand   = sel & ({WORD_BITS{1'b1}} << bit_r);
  assign hit    = |cand;
  assign onehot = cand & (~cand + 1'b1);

  // encode the isolated lowest bit
  always_comb begin
    pos = '0;
    for (int k = 0; k < POS_W; k++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (((i >> k) & 1) == 1) begin
          pos[k] = pos[k] | onehot[i];
        end
      end
    end
  end

  assign cand_idx  = base_r + EW'(pos);
  assign last_word = (base_r + EW'(WORD_BITS)) >= eff_end;
  assign answer    = (hit && (cand_idx < EW'(limit_r))) ? cand_idx[IDX_W-1:0] : limit_r;

  // status
  assign sts.early = EW'(offset_r) >= eff_end;
  assign sts.done  = hit || last_word;
  assign res_load  = (cmd.div && sts.early) || (cmd.scan && sts.done);

  // search registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_set_r <= (in_action == ACT_FIND_SET);
      limit_r    <= in_bit_limit;
      offset_r   <= in_start_offset;
    end
    if (cmd.div) begin
      q_r <= q_nxt;
    end
    if (cmd.setup) begin
      w_r    <= AW'(q_r);
      bit_r  <= bit_diff[POS_W-1:0];
      base_r <= base_nxt;
    end else if (cmd.scan && !sts.done) begin
      w_r    <= w_next[AW-1:0];
      bit_r  <= '0;
      base_r <= base_r + EW'(WORD_BITS);
    end
    if (cmd.div && sts.early) begin
      res_r <= limit_r;
    end else if (cmd.scan && sts.done) begin
      res_r <= answer;
    end
    if (cmd.out_load) begin
      out_found_r <= res_r;
    end
  end

  assign out_found_index = out_found_r;

`ifndef SYNTHESIS
  // the word split puts the offset inside the selected word
  a_split: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.setup |=> ((base_r <= EW'(offset_r)) && (EW'(offset_r) < base_r + EW'(WORD_BITS))))
    else $error("offset not inside its word");

  // scanning never runs past the bitmap
  a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (int'(w_r) < WORDS))
    else $error("word pointer out of range");

  // an answer never exceeds the limit
  a_res_limit: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (res_r <= limit_r))
    else $error("answer beyond limit");

  // an answer below the limit is at or after the offset
  a_res_offset: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> ((res_r == limit_r) || (res_r >= offset_r)))
    else $error("answer before offset");
`endif

endmodule

/* rtl/bitmap_find_next_set_or_zero.sv */
// ----------------------------------------------------------------------------
// bitmap_find_next_set_or_zero
// Write item: taken back to back. Search item: divide, setup, first read,
// then a scan of k words (1..WORDS), one bitmap word per cycle through the
// single read port, then post; from divide straight to post when the offset
// is at or past the limit or the bitmap end. One search at a time; the next
// item is accepted when the answer has moved to the output register.
// Reset clears the sequencer and output valid; bitmap words hold no reset.
// ----------------------------------------------------------------------------
module bitmap_find_next_set_or_zero
  import bfns_pkg::*;
#(
  parameter int WORDS     = WORDS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // word_index[5:0], word_data[69:6], bit_limit[82:70], start_offset[95:83]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // found_index[12:0], zero fill[15:13]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  bfns_cmd_t           cmd;
  bfns_sts_t           sts;
  logic [ACTION_W-1:0] in_action;
  logic [WIDX_W-1:0]   in_word_index;
  logic [DATA_W-1:0]   in_word_data;
  logic [IDX_W-1:0]    in_bit_limit;
  logic [IDX_W-1:0]    in_start_offset;
  logic [IDX_W-1:0]    out_found_index;

  // unpack the input item
  assign in_action       = in_tuser[ACTION_W-1:0];
  assign in_word_index   = in_tdata[5:0];
  assign in_word_data    = in_tdata[69:6];
  assign in_bit_limit    = in_tdata[82:70];
  assign in_start_offset = in_tdata[95:83];

  assign out_tdata = {{(OUT_TDATA_W - IDX_W){1'b0}}, out_found_index};

  bfns_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_action),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  bfns_dp #(
    .WORDS     (WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_word_index   (in_word_index),
    .in_word_data    (in_word_data),
    .in_bit_limit    (in_bit_limit),
    .in_start_offset (in_start_offset),
    .out_found_index (out_found_index)
  );

endmodule
